[design/ida_pkg.sv]
`default_nettype none
// ============================================================================
// ida_pkg: shared constants for the entity ID allocator
// Action and status codes and the default table size.
// ============================================================================
package ida_pkg;

    // default number of entity IDs (IDs run 1..MAX_ENTITIES)
    localparam int MAX_ENTITIES_DEF = 1024;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int SIG_W    = 32;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_NEW    = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_FIND   = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOT_LIVE = 2'd1;
    localparam status_t ST_FULL     = 2'd2;

endpackage : ida_pkg
`default_nettype wire

[design/ida_ram.sv]
`default_nettype none
// ============================================================================
// ida_ram: simple dual-port RAM
// One write port, one read port, registered read data with read enable.
// A read and a write to the same address in one cycle returns old data.
// ============================================================================
module ida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule : ida_ram
`default_nettype wire

[design/id_allocator_free_stack.sv]
`default_nettype none
// ============================================================================
// id_allocator_free_stack: entity ID allocator with a LIFO free stack
// New / delete / find over a signature table; freed IDs are reused
// most-recent first, otherwise the next never-used ID is claimed.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_stall  | action, entity_id, signature_in
//  rsp     | out       | rsp_valid/rsp_stall  | result_id, signature_out, status
//
// One transaction per cycle sustained while rsp is not stalled, set by the single
// read and write port of each RAM. The request and both RAM reads register at
// the accepting edge; the result register and rsp_valid load when execute fires.
// Reset clears the counters and valid flags only: the high-water mark acts as
// the table fill count, so entries above it are never live and need no clearing.
// A stalled response holds the execute stage, which in turn stalls req.
//
module id_allocator_free_stack #(
    parameter int MAX_ENTITIES = ida_pkg::MAX_ENTITIES_DEF,
    parameter int ID_W = $clog2(MAX_ENTITIES + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [ida_pkg::ACTION_W-1:0] action,
    input  wire logic [ID_W-1:0]            entity_id,
    input  wire logic [ida_pkg::SIG_W-1:0]  signature_in,
    // response channel
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic      [ID_W-1:0]            result_id,
    output logic      [ida_pkg::SIG_W-1:0]  signature_out,
    output logic      [ida_pkg::STATUS_W-1:0] status
);

    localparam int ADDR_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int SIG_W  = ida_pkg::SIG_W;
    localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_ENTITIES);
    localparam logic [ID_W-1:0] ONE_ID = ID_W'(1);

    // ------------------------------------------------------------------
    // Execute stage (request captured, RAM reads in flight)
    // ------------------------------------------------------------------
    logic                  ex_valid_reg;
    ida_pkg::action_t      ex_action_reg;
    logic [ID_W-1:0]       ex_id_reg;
    logic [SIG_W-1:0]      ex_sig_reg;

    // bypass of a write that landed in the same cycle as the read
    logic                  info_fwd_hit_reg;
    logic [SIG_W-1:0]      info_fwd_data_reg;
    logic                  stk_fwd_hit_reg;
    logic [ID_W-1:0]       stk_fwd_data_reg;

    // allocator state
    logic [ID_W-1:0]       free_count_reg, free_count_next;
    logic [ID_W-1:0]       high_water_reg, high_water_next;

    // response register
    logic                  rsp_valid_reg;
    logic [ID_W-1:0]       result_id_reg, result_id_next;
    logic [SIG_W-1:0]      signature_out_reg, signature_out_next;
    ida_pkg::status_t      status_reg, status_next;

    // RAM ports
    logic                  info_we;
    logic [ADDR_W-1:0]     info_waddr;
    logic [SIG_W-1:0]      info_wdata;
    logic [ADDR_W-1:0]     info_raddr;
    logic [SIG_W-1:0]      info_rdata;
    logic                  stk_we;
    logic [ADDR_W-1:0]     stk_waddr;
    logic [ID_W-1:0]       stk_wdata;
    logic [ADDR_W-1:0]     stk_raddr;
    logic [ID_W-1:0]       stk_rdata;

    logic                  rsp_free;
    logic                  exec;
    logic                  req_accept;
    logic [SIG_W-1:0]      info_q;
    logic [ID_W-1:0]       stk_q;
    logic                  live;
    logic [ID_W-1:0]       new_id;
    logic [ID_W-1:0]       id_less_one;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign exec       = ex_valid_reg && rsp_free;
    assign req_stall  = ex_valid_reg && !rsp_free;
    assign req_accept = req_valid && !req_stall;

    // RAM data as seen by the execute stage, with same-cycle write bypass
    assign info_q = info_fwd_hit_reg ? info_fwd_data_reg : info_rdata;
    assign stk_q  = stk_fwd_hit_reg  ? stk_fwd_data_reg  : stk_rdata;

    assign id_less_one = ex_id_reg - ONE_ID;

    // live: nonzero ID at or below high water with a nonzero signature
    assign live = (ex_id_reg != '0) && (ex_id_reg <= high_water_reg) && (info_q != '0);

    // ------------------------------------------------------------------
    // Execute logic
    // ------------------------------------------------------------------
    always_comb
    begin
        free_count_next    = free_count_reg;
        high_water_next    = high_water_reg;
        result_id_next     = ex_id_reg;
        signature_out_next = '0;
        status_next        = ida_pkg::ST_NOT_LIVE;
        info_we            = 1'b0;
        info_waddr         = id_less_one[ADDR_W-1:0];
        info_wdata         = '0;
        stk_we             = 1'b0;
        stk_waddr          = free_count_reg[ADDR_W-1:0];
        stk_wdata          = ex_id_reg;
        new_id             = '0;

        case (ex_action_reg)
            ida_pkg::ACT_NEW:
            begin
                if (free_count_reg != '0)
                begin
                    // pop the most recently freed ID
                    free_count_next = free_count_reg - ONE_ID;
                    new_id          = stk_q;
                    status_next     = ida_pkg::ST_OK;
                end
                else if (high_water_reg < MAX_ID)
                begin
                    // claim a never-used ID
                    high_water_next = high_water_reg + ONE_ID;
                    new_id          = high_water_reg + ONE_ID;
                    status_next     = ida_pkg::ST_OK;
                end
                else
                begin
                    status_next = ida_pkg::ST_FULL;
                end
                result_id_next = new_id;
                info_we        = exec && (status_next == ida_pkg::ST_OK);
                info_waddr     = ADDR_W'(new_id - ONE_ID);
                info_wdata     = ex_sig_reg;
            end
            ida_pkg::ACT_DELETE:
            begin
                if (live && (free_count_reg < MAX_ID))
                begin
                    info_we         = exec;
                    stk_we          = exec;
                    free_count_next = free_count_reg + ONE_ID;
                    status_next     = ida_pkg::ST_OK;
                end
            end
            ida_pkg::ACT_FIND:
            begin
                if (live)
                begin
                    signature_out_next = info_q;
                    status_next        = ida_pkg::ST_OK;
                end
            end
            default:
            begin
                // unused action: echo the ID, report not live
            end
        endcase

        if (!exec)
        begin
            free_count_next = free_count_reg;
            high_water_next = high_water_reg;
        end
    end

    // read addresses for the transaction entering this cycle; the stack
    // top follows the count as it stands after the current execute
    assign info_raddr = ADDR_W'(entity_id - ONE_ID);
    assign stk_raddr  = ADDR_W'(free_count_next - ONE_ID);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            free_count_reg <= '0;
            high_water_reg <= '0;
        end
        else
        begin
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            if (req_accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_free)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            ex_action_reg     <= action;
            ex_id_reg         <= entity_id;
            ex_sig_reg        <= signature_in;
            info_fwd_hit_reg  <= info_we && (info_waddr == info_raddr);
            info_fwd_data_reg <= info_wdata;
            stk_fwd_hit_reg   <= stk_we && (stk_waddr == stk_raddr);
            stk_fwd_data_reg  <= stk_wdata;
        end
        if (exec)
        begin
            result_id_reg     <= result_id_next;
            signature_out_reg <= signature_out_next;
            status_reg        <= status_next;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    ida_ram #(
        .WIDTH  (SIG_W),
        .DEPTH  (MAX_ENTITIES),
        .ADDR_W (ADDR_W)
    ) u_info_table (
        .clk     (clk),
        .wr_en   (info_we),
        .wr_addr (info_waddr),
        .wr_data (info_wdata),
        .rd_en   (req_accept),
        .rd_addr (info_raddr),
        .rd_data (info_rdata)
    );

    ida_ram #(
        .WIDTH  (ID_W),
        .DEPTH  (MAX_ENTITIES),
        .ADDR_W (ADDR_W)
    ) u_free_stack (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (req_accept),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    assign rsp_valid     = rsp_valid_reg;
    assign result_id     = result_id_reg;
    assign signature_out = signature_out_reg;
    assign status        = status_reg;

endmodule : id_allocator_free_stack
`default_nettype wire
